// ===== rtl/core/bpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the button press action and UID stepper.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned UID_MAX_BYTES = 16;
  localparam int unsigned UID_IDX_W     = $clog2(UID_MAX_BYTES);
  localparam int unsigned UID_CNT_W     = $clog2(UID_MAX_BYTES + 1);

  // Input operations.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Action codes that step the UID; the others are only reported.
  localparam logic [3:0] ACT_LEFT_INC  = 4'd2;
  localparam logic [3:0] ACT_RIGHT_INC = 4'd3;
  localparam logic [3:0] ACT_LEFT_DEC  = 4'd4;
  localparam logic [3:0] ACT_RIGHT_DEC = 4'd5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LONG_TICKS   = 3'd0;
  localparam logic [2:0] CFG_UID_LENGTH   = 3'd1;
  localparam logic [2:0] CFG_RIGHT_SHORT  = 3'd2;
  localparam logic [2:0] CFG_RIGHT_LONG   = 3'd3;
  localparam logic [2:0] CFG_LEFT_SHORT   = 3'd4;
  localparam logic [2:0] CFG_LEFT_LONG    = 3'd5;

  localparam logic [7:0] LONG_TICKS_RST = 8'd10;
  localparam logic [4:0] UID_LENGTH_RST = 5'd7;

  localparam logic BTN_RIGHT  = 1'b0;
  localparam logic BTN_LEFT   = 1'b1;
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic       right_down;
    logic       left_down;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic       which_button;
    logic       long_press;
    logic [3:0] action_code;
    logic [7:0] data_byte;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [7:0] long_press_ticks;
    logic [4:0] uid_length;
    logic [3:0] right_short_action;
    logic [3:0] right_long_action;
    logic [3:0] left_short_action;
    logic [3:0] left_long_action;
  } cfg_t;

  // Events raised by one tick, right button first.
  typedef struct packed {
    logic       r_fire;
    logic       r_long;
    logic [3:0] r_code;
    logic       l_fire;
    logic       l_long;
    logic [3:0] l_code;
  } press_ev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_STEP_RD,
    ST_STEP_WR,
    ST_RD_OUT
  } state_e;

endpackage

// ===== rtl/core/bpa_uid_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_uid_mem
// UID byte store: one write and one registered read port, with a valid bit
// per byte so that the store reads as zero after reset.
// ----------------------------------------------------------------------------
module bpa_uid_mem
  import bpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [UID_IDX_W-1:0] waddr_i,
  input  logic [7:0]           wdata_i,
  input  logic                 re_i,
  input  logic [UID_IDX_W-1:0] raddr_i,
  output logic [7:0]           rdata_o
);

  logic [7:0]               mem [UID_MAX_BYTES];
  logic [UID_MAX_BYTES-1:0] vld_q;
  logic [7:0]               rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // A byte never written since reset reads as zero.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= vld_q[raddr_i] ? mem[raddr_i] : 8'h00;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bpa_press.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_press
// Press counters for both buttons and the short/long classification.
// ----------------------------------------------------------------------------
module bpa_press
  import bpa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      tick_i,
  input  logic      right_down_i,
  input  logic      left_down_i,
  input  cfg_t      cfg_i,
  output press_ev_t ev_o
);

  typedef struct packed {
    logic       fire;
    logic       is_long;
    logic [7:0] cnt_nxt;
  } btn_upd_t;

  function automatic btn_upd_t btn_update(input logic [7:0] cnt, input logic held,
                                          input logic none_held, input logic [7:0] thr);
    btn_upd_t r;
    r.fire    = 1'b0;
    r.is_long = 1'b0;
    r.cnt_nxt = cnt;
    if (held) begin
      if (cnt < thr) begin
        r.cnt_nxt = cnt + 8'd1;
      end else if (cnt == thr) begin
        // Past the threshold, held ticks stay quiet unless the count wraps.
        r.fire    = 1'b1;
        r.is_long = 1'b1;
        r.cnt_nxt = cnt + 8'd1;
      end
    end else if (none_held) begin
      r.fire    = (cnt != 8'd0) && (cnt <= thr);
      r.cnt_nxt = 8'd0;
    end
    return r;
  endfunction

  logic [7:0] right_cnt_q, right_cnt_d;
  logic [7:0] left_cnt_q, left_cnt_d;
  logic       none_held;
  btn_upd_t   r_upd, l_upd;

  assign none_held = !right_down_i && !left_down_i;

  always_comb begin
    r_upd = btn_update(right_cnt_q, right_down_i, none_held, cfg_i.long_press_ticks);
    l_upd = btn_update(left_cnt_q, left_down_i, none_held, cfg_i.long_press_ticks);
    right_cnt_d = tick_i ? r_upd.cnt_nxt : right_cnt_q;
    left_cnt_d  = tick_i ? l_upd.cnt_nxt : left_cnt_q;
  end

  always_comb begin
    ev_o.r_fire = r_upd.fire;
    ev_o.r_long = r_upd.is_long;
    ev_o.r_code = r_upd.is_long ? cfg_i.right_long_action : cfg_i.right_short_action;
    ev_o.l_fire = l_upd.fire;
    ev_o.l_long = l_upd.is_long;
    ev_o.l_code = l_upd.is_long ? cfg_i.left_long_action : cfg_i.left_short_action;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_cnt_q <= 8'd0;
      left_cnt_q  <= 8'd0;
    end else begin
      right_cnt_q <= right_cnt_d;
      left_cnt_q  <= left_cnt_d;
    end
  end

endmodule

// ===== rtl/core/button_press_action_uid_stepper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_action_uid_stepper
// Two-button short/long press classifier with a byte-serial UID stepper.
// ----------------------------------------------------------------------------
// Usage: input beats on in_* carry a tick (button levels), a UID byte write
// or a UID byte read. A tick yields zero, one or two action events (right
// before left); a read yields one data beat; a write yields none. The last
// result of each input beat has last set. Configuration must be written
// through cfg_we_i/cfg_idx_i/cfg_wdata_i while the block is idle; the block
// itself does not enforce this. Each increment or decrement steps the UID
// bytes by a read-modify-write on the single UID store, one byte at a time
// (ST_STEP_RD, then ST_STEP_WR), stopping when the carry ends or the used
// length is reached.
// The block takes one input beat at a time; in_ready_o is high when it is
// idle, even while a finished result still waits in the output register.
// A stalled receiver holds the result there and pauses the sequencer.
// Reset clears the counters, the configuration to defaults and the whole
// UID store to zero at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module button_press_action_uid_stepper
  import bpa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  state_e state_q, state_d;
  cfg_t   cfg_q;

  press_ev_t ev, ev_q;
  logic      slot_q;
  logic      rd_ok_q;

  logic [UID_CNT_W-1:0] k_q, n_q, k_inc, len_used;
  logic                 up_q, low_q;

  logic                 out_valid_q, out_valid_d, out_load, out_free;
  out_t                 out_q, out_d;

  logic                 mem_we, mem_re;
  logic [UID_IDX_W-1:0] mem_waddr, mem_raddr, walk_addr, in_addr;
  logic [7:0]           mem_wdata, mem_rdata, step_byte;

  logic       in_acc, is_tick, is_read, is_write, idx_ok, any_fire;
  logic [3:0] cur_code;
  logic       cur_long, cur_last, is_step, start_walk, walk_more, finish;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks   <= LONG_TICKS_RST;
      cfg_q.uid_length         <= UID_LENGTH_RST;
      cfg_q.right_short_action <= 4'd0;
      cfg_q.right_long_action  <= 4'd0;
      cfg_q.left_short_action  <= 4'd0;
      cfg_q.left_long_action   <= 4'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LONG_TICKS:  cfg_q.long_press_ticks   <= cfg_wdata_i;
        CFG_UID_LENGTH:  cfg_q.uid_length         <= cfg_wdata_i[4:0];
        CFG_RIGHT_SHORT: cfg_q.right_short_action <= cfg_wdata_i[3:0];
        CFG_RIGHT_LONG:  cfg_q.right_long_action  <= cfg_wdata_i[3:0];
        CFG_LEFT_SHORT:  cfg_q.left_short_action  <= cfg_wdata_i[3:0];
        CFG_LEFT_LONG:   cfg_q.left_long_action   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- decoding
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_tick    = in_acc && (in_data_i.action == OP_TICK);
  assign is_write   = in_acc && (in_data_i.action == OP_WRITE);
  assign is_read    = in_acc && (in_data_i.action == OP_READ);
  assign idx_ok     = 32'(in_data_i.byte_index) < UID_MAX_BYTES;
  assign in_addr    = UID_IDX_W'(in_data_i.byte_index);
  assign any_fire   = ev.r_fire || ev.l_fire;

  bpa_press u_press (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (is_tick),
    .right_down_i (in_data_i.right_down),
    .left_down_i  (in_data_i.left_down),
    .cfg_i        (cfg_q),
    .ev_o         (ev)
  );

  assign cur_code = (slot_q == BTN_LEFT) ? ev_q.l_code : ev_q.r_code;
  assign cur_long = (slot_q == BTN_LEFT) ? ev_q.l_long : ev_q.r_long;
  assign cur_last = (slot_q == BTN_LEFT) || !ev_q.l_fire;
  assign is_step  = (cur_code == ACT_LEFT_INC) || (cur_code == ACT_RIGHT_INC) ||
                    (cur_code == ACT_LEFT_DEC) || (cur_code == ACT_RIGHT_DEC);

  assign len_used   = (32'(cfg_q.uid_length) > UID_MAX_BYTES) ?
                      UID_CNT_W'(UID_MAX_BYTES) : UID_CNT_W'(cfg_q.uid_length);
  assign out_free   = !out_valid_q || out_ready_i;
  assign start_walk = is_step && (len_used != '0);

  // ------------------------------------------------------------- UID walk
  assign k_inc     = k_q + UID_CNT_W'(1);
  assign walk_addr = low_q ? UID_IDX_W'(k_q) : UID_IDX_W'(n_q - k_q - UID_CNT_W'(1));
  assign step_byte = up_q ? (mem_rdata + 8'd1) : (mem_rdata - 8'd1);
  assign walk_more = (up_q ? (mem_rdata == 8'hFF) : (mem_rdata == 8'h00)) && (k_inc < n_q);
  assign finish    = ((state_q == ST_EMIT) && out_free && !start_walk) ||
                     ((state_q == ST_STEP_WR) && !walk_more);

  bpa_uid_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ----------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_tick && any_fire) begin
          state_d = ST_EMIT;
        end else if (is_read) begin
          state_d = ST_RD_OUT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (start_walk) begin
            state_d = ST_STEP_RD;
          end else if (cur_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_STEP_RD: state_d = ST_STEP_WR;
      ST_STEP_WR: begin
        if (walk_more) begin
          state_d = ST_STEP_RD;
        end else if (cur_last) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_RD_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------- outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_addr;
    mem_wdata = in_data_i.byte_value;
    mem_re    = 1'b0;
    mem_raddr = in_addr;
    out_load  = 1'b0;
    out_d     = out_q;
    unique case (state_q)
      ST_IDLE: begin
        mem_we = is_write && idx_ok;
        mem_re = is_read;
      end
      ST_EMIT: begin
        out_load           = out_free;
        out_d.kind         = KIND_EVENT;
        out_d.which_button = slot_q;
        out_d.long_press   = cur_long;
        out_d.action_code  = cur_code;
        out_d.data_byte    = 8'h00;
        out_d.last         = cur_last;
      end
      ST_STEP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = walk_addr;
      end
      ST_STEP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = walk_addr;
        mem_wdata = step_byte;
      end
      ST_RD_OUT: begin
        out_load           = out_free;
        out_d.kind         = KIND_READ;
        out_d.which_button = 1'b0;
        out_d.long_press   = 1'b0;
        out_d.action_code  = 4'd0;
        out_d.data_byte    = rd_ok_q ? mem_rdata : 8'h00;
        out_d.last         = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      slot_q      <= BTN_RIGHT;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (is_tick) begin
        slot_q <= ev.r_fire ? BTN_RIGHT : BTN_LEFT;
      end else if (finish && !cur_last) begin
        slot_q <= BTN_LEFT;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
    if (is_tick) begin
      ev_q <= ev;
    end
    if (is_read) begin
      rd_ok_q <= idx_ok;
    end
    if ((state_q == ST_EMIT) && out_free && start_walk) begin
      k_q   <= '0;
      n_q   <= len_used;
      up_q  <= (cur_code == ACT_LEFT_INC) || (cur_code == ACT_RIGHT_INC);
      low_q <= (cur_code == ACT_LEFT_INC) || (cur_code == ACT_LEFT_DEC);
    end else if ((state_q == ST_STEP_WR) && walk_more) begin
      k_q <= k_inc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ------------------------------------------------------------ assertions
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP_RD) |-> (k_q < n_q))
    else $error("UID walk beyond the used length");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP_WR) |-> ($past(state_q) == ST_STEP_RD))
    else $error("UID byte written back without a preceding read");

  a_emit_has_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> ((slot_q == BTN_RIGHT && ev_q.r_fire) ||
                              (slot_q == BTN_LEFT && ev_q.l_fire)))
    else $error("Event slot selected that did not fire");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("Output register overwritten before its beat was taken");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-button press classifier and UID stepper.
// A queue-fed driver offers input beats. Each accepted beat runs through a
// local model of the counters, the configured action codes and the UID
// store, and the model's results are queued. A monitor compares every result
// beat with the oldest queued result, field by field. Directed beats come
// first, then bursts of press sequences, UID reads and writes, and noise,
// under a range of configurations. Random gaps and back-pressure are applied
// on both sides.
// ----------------------------------------------------------------------------
module tb;
  import bpa_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [3:0] ACT_NONE       = 4'd0;
  localparam logic [3:0] ACT_RANDOM     = 4'd1;
  localparam logic [3:0] ACT_CYCLE      = 4'd6;
  localparam logic [3:0] ACT_STORE      = 4'd7;
  localparam logic [3:0] ACT_RECALL     = 4'd8;
  localparam logic [3:0] ACT_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] ACT_UNKNOWN_HI = 4'd15;

  localparam int IDLE_PCT   = 19;
  localparam int SETTLE_GAP = 80;
  localparam int RX_HOLD    = 300;
  localparam int MAX_SHOWN  = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_beat = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_beat;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [7:0] cfg_wdata = '0;

  button_press_action_uid_stepper DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Model state.
  cfg_t       press_cfg;
  logic [7:0] right_hold;
  logic [7:0] left_hold;
  logic [7:0] uid_bytes [UID_MAX_BYTES];

  in_t  pending_beats [$];
  out_t expected_beats [$];

  int   fail_cnt = 0;
  int   tx_idle_pct = IDLE_PCT;
  int   rx_idle_pct = IDLE_PCT;
  logic rx_long_req = 1'b0;
  logic rx_long_done = 1'b0;
  int   rx_hold_cnt = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void note_failure(input string msg);
    if (fail_cnt < MAX_SHOWN) $display("MISMATCH: %s", msg);
    fail_cnt++;
  endfunction

  // Walks the UID bytes in use, stopping as soon as the carry or borrow ends.
  function automatic void step_uid(input bit up, input bit from_low);
    int         n;
    int         k;
    int         idx;
    logic [7:0] b;
    bit         carry;
    n = (press_cfg.uid_length > UID_MAX_BYTES) ? UID_MAX_BYTES : press_cfg.uid_length;
    carry = 1'b1;
    for (k = 0; k < n && carry; k++) begin
      idx = from_low ? k : n - 1 - k;
      b = uid_bytes[idx];
      uid_bytes[idx] = up ? b + 8'd1 : b - 8'd1;
      carry = up ? (b == 8'hFF) : (b == 8'h00);
    end
  endfunction

  function automatic out_t fire_action(input logic btn, input logic lng,
                                       input logic [3:0] code);
    out_t r;
    case (code)
      ACT_LEFT_INC:  step_uid(1'b1, 1'b1);
      ACT_RIGHT_INC: step_uid(1'b1, 1'b0);
      ACT_LEFT_DEC:  step_uid(1'b0, 1'b1);
      ACT_RIGHT_DEC: step_uid(1'b0, 1'b0);
      default: ;
    endcase
    r = '0;
    r.kind         = KIND_EVENT;
    r.which_button = btn;
    r.long_press   = lng;
    r.action_code  = code;
    return r;
  endfunction

  function automatic void update_press(inout logic [7:0] cnt, input logic held,
                                       input logic none_held,
                                       input logic [3:0] short_code,
                                       input logic [3:0] long_code,
                                       output logic fire, output logic lng,
                                       output logic [3:0] code);
    fire = 1'b0;
    lng  = 1'b0;
    code = short_code;
    if (held) begin
      if (cnt < press_cfg.long_press_ticks) begin
        cnt = cnt + 8'd1;
      end else if (cnt == press_cfg.long_press_ticks) begin
        fire = 1'b1;
        lng  = 1'b1;
        code = long_code;
        cnt  = cnt + 8'd1;
      end
    end else if (none_held) begin
      if (cnt != 8'd0 && cnt <= press_cfg.long_press_ticks) fire = 1'b1;
      cnt = 8'd0;
    end
  endfunction

  function automatic void classify_and_step(input in_t b);
    out_t       res [$];
    out_t       r;
    logic       none_held;
    logic       fire;
    logic       lng;
    logic [3:0] code;
    none_held = !b.right_down && !b.left_down;
    case (b.action)
      OP_TICK: begin
        // The right button is settled first, so its UID step lands first.
        update_press(right_hold, b.right_down, none_held, press_cfg.right_short_action,
                     press_cfg.right_long_action, fire, lng, code);
        if (fire) res.push_back(fire_action(BTN_RIGHT, lng, code));
        update_press(left_hold, b.left_down, none_held, press_cfg.left_short_action,
                     press_cfg.left_long_action, fire, lng, code);
        if (fire) res.push_back(fire_action(BTN_LEFT, lng, code));
      end
      OP_WRITE: uid_bytes[b.byte_index] = b.byte_value;
      OP_READ: begin
        r = '0;
        r.kind      = KIND_READ;
        r.data_byte = uid_bytes[b.byte_index];
        res.push_back(r);
      end
      default: ;
    endcase
    if (res.size() != 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_beats.push_back(res[i]);
  endfunction

  // Driver: predicts each accepted beat, then offers the next one.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_beat  <= '0;
    end else begin
      if (in_valid && in_ready) classify_and_step(in_beat);
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_beat  <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result beats and applies back-pressure.
  always @(posedge clk or negedge rst_n) begin
    out_t want;
    if (!rst_n) begin
      out_ready    <= 1'b0;
      rx_hold_cnt  <= 0;
      rx_long_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          note_failure($sformatf("unexpected result %p", out_beat));
        end else begin
          want = expected_beats.pop_front();
          if (out_beat.kind !== want.kind || out_beat.which_button !== want.which_button ||
              out_beat.long_press !== want.long_press ||
              out_beat.action_code !== want.action_code ||
              out_beat.data_byte !== want.data_byte || out_beat.last !== want.last)
            note_failure($sformatf("expected %p, got %p", want, out_beat));
        end
      end
      if (rx_long_req && !rx_long_done) begin
        out_ready   <= 1'b0;
        rx_hold_cnt <= rx_hold_cnt + 1;
        if (rx_hold_cnt == RX_HOLD - 1) rx_long_done <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic in_t make_item(input logic [1:0] op, input logic r, input logic l,
                                    input logic [3:0] idx, input logic [7:0] val);
    in_t b;
    b.action     = op;
    b.right_down = r;
    b.left_down  = l;
    b.byte_index = idx;
    b.byte_value = val;
    return b;
  endfunction

  // The index and value of a tick are ignored, so they are left random.
  function automatic void add_tick(input logic r, input logic l);
    pending_beats.push_back(make_item(OP_TICK, r, l, 4'($urandom), 8'($urandom)));
  endfunction

  function automatic logic [3:0] pick_code();
    if ($urandom_range(99) < 70) return 4'($urandom_range(ACT_RIGHT_DEC, ACT_LEFT_INC));
    return 4'($urandom);
  endfunction

  function automatic void add_burst(input int n);
    int         made;
    int         pick;
    int         hold;
    int         lim;
    int         mode;
    logic       r;
    logic       l;
    logic [7:0] val;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        lim  = (press_cfg.long_press_ticks > 12) ? 12 : press_cfg.long_press_ticks;
        hold = $urandom_range(lim + 3, 1);
        mode = $urandom_range(3);
        repeat (hold) begin
          case (mode)
            0: {r, l} = 2'b10;
            1: {r, l} = 2'b01;
            2: {r, l} = 2'b11;
            default: {r, l} = 2'($urandom_range(3, 1));
          endcase
          add_tick(r, l);
          made++;
        end
        repeat ($urandom_range(2, 1)) begin
          add_tick(1'b0, 1'b0);
          made++;
        end
      end else if (pick < 80) begin
        // Bytes at the ends of the range make the carry chains run long.
        case ($urandom_range(2))
          0: val = 8'hFF;
          1: val = 8'h00;
          default: val = 8'($urandom);
        endcase
        pending_beats.push_back(make_item(OP_WRITE, 1'($urandom), 1'($urandom),
                                          4'($urandom), val));
        made++;
      end else if (pick < 90) begin
        pending_beats.push_back(make_item(OP_READ, 1'($urandom), 1'($urandom),
                                          4'($urandom), 8'($urandom)));
        made++;
      end else begin
        pending_beats.push_back(in_t'(16'($urandom)));
        made++;
      end
    end
  endfunction

  task automatic wait_idle(input int gap);
    while (pending_beats.size() != 0 || in_valid || expected_beats.size() != 0)
      @(negedge clk);
    repeat (gap) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LONG_TICKS:  press_cfg.long_press_ticks   = val;
      CFG_UID_LENGTH:  press_cfg.uid_length         = val[4:0];
      CFG_RIGHT_SHORT: press_cfg.right_short_action = val[3:0];
      CFG_RIGHT_LONG:  press_cfg.right_long_action  = val[3:0];
      CFG_LEFT_SHORT:  press_cfg.left_short_action  = val[3:0];
      CFG_LEFT_LONG:   press_cfg.left_long_action   = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] ticks, input logic [7:0] len,
                            input logic [3:0] rs, input logic [3:0] rl,
                            input logic [3:0] ls, input logic [3:0] ll);
    wait_idle(SETTLE_GAP);
    write_reg(CFG_LONG_TICKS, ticks);
    write_reg(CFG_UID_LENGTH, len);
    write_reg(CFG_RIGHT_SHORT, {4'd0, rs});
    write_reg(CFG_RIGHT_LONG, {4'd0, rl});
    write_reg(CFG_LEFT_SHORT, {4'd0, ls});
    write_reg(CFG_LEFT_LONG, {4'd0, ll});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int ph;
    press_cfg = '0;
    press_cfg.long_press_ticks = LONG_TICKS_RST;
    press_cfg.uid_length       = UID_LENGTH_RST;
    right_hold = '0;
    left_hold  = '0;
    foreach (uid_bytes[i]) uid_bytes[i] = 8'h00;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: the store reads back cleared, a short press
    // reports the default code.
    pending_beats.push_back(make_item(OP_READ, 1'b0, 1'b0, 4'd5, 8'h00));
    add_tick(1'b1, 1'b0);
    add_tick(1'b0, 1'b0);

    set_config(8'd2, 8'd16, ACT_LEFT_INC, ACT_RIGHT_INC, ACT_LEFT_DEC, ACT_RIGHT_DEC);
    pending_beats.push_back(make_item(OP_WRITE, 1'b0, 1'b0, 4'd0, 8'hFF));
    pending_beats.push_back(make_item(OP_WRITE, 1'b1, 1'b1, 4'd1, 8'hFF));
    pending_beats.push_back(make_item(OP_WRITE, 1'b0, 1'b0, 4'd15, 8'h00));
    pending_beats.push_back(make_item(OP_WRITE, 1'b0, 1'b1, 4'd8, 8'hA5));
    add_tick(1'b1, 1'b0);
    add_tick(1'b0, 1'b0);
    pending_beats.push_back(make_item(OP_READ, 1'b0, 1'b0, 4'd1, 8'h00));
    pending_beats.push_back(make_item(OP_READ, 1'b1, 1'b0, 4'd2, 8'hFF));
    repeat (4) add_tick(1'b1, 1'b0);   // long fires on the third, the fourth is ignored
    add_tick(1'b0, 1'b0);
    add_tick(1'b0, 1'b1);
    add_tick(1'b0, 1'b0);
    repeat (3) add_tick(1'b1, 1'b1);   // both long actions fire on one tick
    add_tick(1'b0, 1'b0);
    // The right count is kept while only the left button is down.
    add_tick(1'b1, 1'b0);
    add_tick(1'b0, 1'b1);
    add_tick(1'b0, 1'b0);
    pending_beats.push_back(make_item(OP_UNUSED, 1'b1, 1'b1, 4'd15, 8'hFF));
    pending_beats.push_back(make_item(OP_READ, 1'b0, 1'b0, 4'd15, 8'h00));

    // Zero threshold, no bytes stepped, the no-op and unknown codes.
    set_config(8'd0, 8'd0, ACT_NONE, ACT_UNKNOWN_LO, ACT_UNKNOWN_HI, ACT_RECALL);
    add_burst(15);

    // Largest threshold: a held press wraps the counter and counts again.
    set_config(8'd255, 8'd31, ACT_RANDOM, ACT_CYCLE, ACT_STORE, ACT_RIGHT_INC);
    repeat (258) add_tick(1'b1, 1'b0);
    add_tick(1'b0, 1'b0);
    add_burst(10);

    set_config(8'd254, 8'd16, pick_code(), pick_code(), pick_code(), pick_code());
    add_burst(10);

    for (ph = 0; ph < 6; ph++) begin
      set_config(8'($urandom_range(8, 1)),
                 ($urandom_range(3) == 0) ? 8'($urandom_range(31, 17))
                                          : 8'($urandom_range(16, 0)),
                 pick_code(), pick_code(), pick_code(), pick_code());
      case (ph)
        0: begin
          rx_long_req = 1'b1;
          add_burst(25);
        end
        1: begin
          add_burst(15);
          wait_idle(0);
          add_burst(15);
        end
        2: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          add_burst(30);
          wait_idle(0);
          tx_idle_pct = IDLE_PCT;
          rx_idle_pct = IDLE_PCT;
        end
        default: add_burst(12);
      endcase
    end

    wait_idle(SETTLE_GAP);
    if (fail_cnt == 0 && expected_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== button_press_action_uid_stepper.f =====
rtl/core/bpa_pkg.sv
rtl/core/bpa_uid_mem.sv
rtl/core/bpa_press.sv
rtl/core/button_press_action_uid_stepper.sv
test/tb.sv
